// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside reset.
`define ASSERT_AR(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cond in a cycle implies res in the next.
`define ASSERT_NEXT(lbl, clk, rstn, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (res)) else $error(msg);

`endif

// ===== rtl/qstp_pkg.sv =====
// ---------------------------------------------------------------------------
// qstp_pkg
// Constants and types of the quaternion smallest-three packer.
// ---------------------------------------------------------------------------
package qstp_pkg;

	localparam int CW_DEFAULT = 32;
	localparam int NUM_COMP   = 4;
	localparam int IDX_W      = 2;

	// round(sqrt2 * 2^32), Q1.32
	localparam int             K_W       = 33;
	localparam logic [K_W-1:0] SQRT2_Q32 = 33'd6074001000;

	localparam logic FMT_SHORT = 1'b0;
	localparam logic FMT_LONG  = 1'b1;

	localparam int SHORT_B     = 10;
	localparam int LONG_B      = 20;
	localparam int SHORT_SHIFT = SHORT_B - 1;
	localparam int LONG_SHIFT  = LONG_B - 1;
	localparam int FIELD_W     = LONG_B;
	localparam int SHORT_PACK  = 2 + 3 * SHORT_B;
	localparam int LONG_PACK   = 2 + 3 * LONG_B;

	localparam logic [FIELD_W-1:0] SHORT_MAX = FIELD_W'((1 << SHORT_SHIFT) - 1);
	localparam logic [FIELD_W-1:0] LONG_MAX  = FIELD_W'((1 << LONG_SHIFT) - 1);

	// Bits of the scaled product kept from the half-LSB rounding position up.
	localparam int ROUND_W = 22;
	localparam int MAG_R_W = ROUND_W - 1;

	localparam int PACK_W     = 64;
	localparam int OUT_DATA_W = 72;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [FIELD_W-1:0] field_t;

endpackage

// ===== rtl/quaternion_smallest_three_pack_top.sv =====
// ---------------------------------------------------------------------------
// quaternion_smallest_three_pack_top
// Smallest-three quaternion packer: drops the largest component, scales the
// other three by M*sqrt2, rounds, saturates and packs them with the index.
//
// Channel  Dir  Width  Content
// s_*      in   4W     comp_w, comp_x, comp_y, comp_z (W bits each)
// m_*      out  72     packed_word[63:0], largest_index[65:64], clipped[66]
// cfg_*    in   1      format_select (0: 10-bit fields, 1: 20-bit fields)
//
// One word per cycle sustained while m_tready stays high. The six pipeline
// stages are: magnitude, pair compare with split multiply, final compare
// with product sum, times-M shift-subtract, round and saturate, pack.
// Each stage advances when it is empty or the next stage advances, so
// bubbles collapse while the output stalls. Reset clears the valid bits
// and format_select.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_smallest_three_pack_top
	import qstp_pkg::*;
#(
	parameter int  COMPONENT_WIDTH = CW_DEFAULT,
	localparam int IN_DATA_W       = ((NUM_COMP * COMPONENT_WIDTH + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // comp_w, comp_x, comp_y, comp_z
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // packed_word, largest_index, clipped
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data   // format_select
);

	localparam int CW      = COMPONENT_WIDTH;
	localparam int FRAC    = CW - 2;
	localparam int MAG_W   = CW - 1;
	localparam int LO_W    = MAG_W / 2;
	localparam int HI_W    = MAG_W - LO_W;
	localparam int PLO_W   = LO_W + K_W;
	localparam int PHI_W   = HI_W + K_W;
	localparam int P_W     = MAG_W + K_W;
	localparam int T_W     = P_W + LONG_SHIFT;
	localparam int RND_LSB = FRAC + 31;

	logic fmt_q;

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [CW-1:0]    mag_s1 [NUM_COMP];
	logic [NUM_COMP-1:0] neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;

	logic [CW-1:0]    mag_a_s2, mag_b_s2;
	idx_t             idx_a_s2, idx_b_s2;
	logic [PLO_W-1:0] plo_s2 [NUM_COMP];
	logic [PHI_W-1:0] phi_s2 [NUM_COMP];

	idx_t             big_s3, big_s4, big_s5;
	logic [P_W-1:0]   p_s3 [NUM_COMP];

	logic [ROUND_W-1:0] th_s4 [NUM_COMP];

	field_t              r_s5 [NUM_COMP];
	logic [NUM_COMP-1:0] clip_s5;

	// Handshake and stage enables
	assign cfg_ready = 1'b1;
	assign en_s6     = !v_s6 || m_tready;
	assign en_s5     = !v_s5 || en_s6;
	assign en_s4     = !v_s4 || en_s5;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign s_tready  = en_s1;
	assign m_tvalid  = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_SHORT;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fmt_q <= cfg_data;
			end
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: sign and magnitude
	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				neg_s1[i] <= s_tdata[i*CW + CW - 1];
				mag_s1[i] <= s_tdata[i*CW + CW - 1] ? (~s_tdata[i*CW +: CW] + CW'(1))
				                                    : s_tdata[i*CW +: CW];
			end
		end
	end

	// Stage 2: pair compare, clamp and split multiply
	logic [MAG_W-1:0] magc [NUM_COMP];

	always_comb begin
		for (int i = 0; i < NUM_COMP; i++) begin
			if (mag_s1[i][CW-1] || (mag_s1[i][FRAC] && (|mag_s1[i][FRAC-1:0])))
				magc[i] = MAG_W'(1) << FRAC;
			else
				magc[i] = mag_s1[i][MAG_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			neg_s2 <= neg_s1;
			if (mag_s1[1] > mag_s1[0]) begin
				mag_a_s2 <= mag_s1[1];
				idx_a_s2 <= idx_t'(1);
			end else begin
				mag_a_s2 <= mag_s1[0];
				idx_a_s2 <= idx_t'(0);
			end
			if (mag_s1[3] > mag_s1[2]) begin
				mag_b_s2 <= mag_s1[3];
				idx_b_s2 <= idx_t'(3);
			end else begin
				mag_b_s2 <= mag_s1[2];
				idx_b_s2 <= idx_t'(2);
			end
			for (int i = 0; i < NUM_COMP; i++) begin
				plo_s2[i] <= PLO_W'(magc[i][LO_W-1:0]) * PLO_W'(SQRT2_Q32);
				phi_s2[i] <= PHI_W'(magc[i][MAG_W-1:LO_W]) * PHI_W'(SQRT2_Q32);
			end
		end
	end

	// Stage 3: final compare, sum partial products
	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			neg_s3 <= neg_s2;
			big_s3 <= (mag_b_s2 > mag_a_s2) ? idx_b_s2 : idx_a_s2;
			for (int i = 0; i < NUM_COMP; i++) begin
				p_s3[i] <= P_W'(plo_s2[i]) + (P_W'(phi_s2[i]) << LO_W);
			end
		end
	end

	// Stage 4: times M as shift-subtract, keep bits from half-LSB up
	logic [T_W-1:0] p_ext [NUM_COMP];
	logic [T_W-1:0] t_val [NUM_COMP];

	always_comb begin
		for (int i = 0; i < NUM_COMP; i++) begin
			p_ext[i] = T_W'(p_s3[i]);
			if (fmt_q == FMT_LONG)
				t_val[i] = (p_ext[i] << LONG_SHIFT) - p_ext[i];
			else
				t_val[i] = (p_ext[i] << SHORT_SHIFT) - p_ext[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			neg_s4 <= neg_s3;
			big_s4 <= big_s3;
			for (int i = 0; i < NUM_COMP; i++) begin
				th_s4[i] <= t_val[i][T_W-1:RND_LSB];
			end
		end
	end

	// Stage 5: round half away from zero, saturate
	logic [ROUND_W-1:0] rsum [NUM_COMP];
	logic [MAG_R_W-1:0] rmag [NUM_COMP];
	field_t             fmax;

	always_comb begin
		fmax = (fmt_q == FMT_LONG) ? LONG_MAX : SHORT_MAX;
		for (int i = 0; i < NUM_COMP; i++) begin
			rsum[i] = th_s4[i] + ROUND_W'(1);
			rmag[i] = rsum[i][ROUND_W-1:1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			neg_s5 <= neg_s4;
			big_s5 <= big_s4;
			for (int i = 0; i < NUM_COMP; i++) begin
				if (rmag[i] > MAG_R_W'(fmax)) begin
					r_s5[i]    <= fmax;
					clip_s5[i] <= 1'b1;
				end else begin
					r_s5[i]    <= rmag[i][FIELD_W-1:0];
					clip_s5[i] <= 1'b0;
				end
			end
		end
	end

	// Stage 6: select the three kept lanes, apply sign, pack
	idx_t                sel [3];
	field_t              fld [3];
	logic                big_neg;
	logic                clip_any;
	logic [PACK_W-1:0]   packed_word;

	always_comb begin
		sel[0]  = (big_s5 == idx_t'(0)) ? idx_t'(1) : idx_t'(0);
		sel[1]  = (big_s5 == idx_t'(0) || big_s5 == idx_t'(1)) ? idx_t'(2) : idx_t'(1);
		sel[2]  = (big_s5 == idx_t'(3)) ? idx_t'(2) : idx_t'(3);
		big_neg = neg_s5[big_s5];
		for (int k = 0; k < 3; k++) begin
			fld[k] = (neg_s5[sel[k]] != big_neg) ? (~r_s5[sel[k]] + FIELD_W'(1))
			                                     : r_s5[sel[k]];
		end
		clip_any = clip_s5[sel[0]] || clip_s5[sel[1]] || clip_s5[sel[2]];
		if (fmt_q == FMT_LONG)
			packed_word = PACK_W'({fld[2], fld[1], fld[0], big_s5});
		else
			packed_word = PACK_W'({fld[2][SHORT_B-1:0], fld[1][SHORT_B-1:0],
			                       fld[0][SHORT_B-1:0], big_s5});
	end

	always_ff @(posedge clk) begin
		if (en_s6 && v_s5) begin
			m_tdata <= OUT_DATA_W'({clip_any, big_s5, packed_word});
		end
	end

	`ASSERT_AR(a_short_upper_zero, clk, arst_n, !(m_tvalid && fmt_q == FMT_SHORT) || (m_tdata[PACK_W-1:SHORT_PACK] == '0), "short format word has upper bits set")
	`ASSERT_AR(a_long_upper_zero, clk, arst_n, !(m_tvalid && fmt_q == FMT_LONG) || (m_tdata[PACK_W-1:LONG_PACK] == '0), "long format word has upper bits set")
	`ASSERT_AR(a_index_match, clk, arst_n, !m_tvalid || (m_tdata[PACK_W +: IDX_W] == m_tdata[IDX_W-1:0]), "index field disagrees with packed index")
	`ASSERT_NEXT(a_accept_loads, clk, arst_n, s_tvalid && s_tready, v_s1, "accepted word missing from first stage")
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, v_s5 && !en_s5, v_s5 && $stable(big_s5), "stalled stage lost its word")

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the smallest-three quaternion packer. A directed
// table of quaternions (zero, extremes, ties, saturation, rounding) runs in
// both field formats. Random phases follow, mostly well-formed quaternions
// with some noise, under several idle and stall patterns. Each output word
// is checked against its typed table result in the first pass where a row
// has one, else against a bench model of drop, scale, round, saturate, pack.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import qstp_pkg::*;

	localparam int CW             = CW_DEFAULT;
	localparam int FRAC           = CW - 2;
	localparam int IN_W           = NUM_COMP * CW;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 10;
	localparam int HOLD_CYCLES    = 300;
	localparam int NO_MARK        = -1;
	localparam int NUM_ROWS       = 21;

	// largest magnitude that stays below the clip point, about 2^30 / sqrt2
	localparam logic [CW-1:0] NEAR_CLIP = 32'h2D41_3CCD;

	localparam idx_t SEL_W = 2'd0;
	localparam idx_t SEL_X = 2'd1;
	localparam idx_t SEL_Y = 2'd2;
	localparam idx_t SEL_Z = 2'd3;

	typedef struct packed {
		logic          clipped;
		idx_t          sel;
		logic [PACK_W-1:0] word;
	} pack_result_t;

	typedef struct packed {
		logic [CW-1:0] w;
		logic [CW-1:0] x;
		logic [CW-1:0] y;
		logic [CW-1:0] z;
		logic          typed;
		pack_result_t  want;
	} quat_row_t;

	localparam quat_row_t QUAT_ROWS [NUM_ROWS] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, SEL_W, 64'h0}},
		'{32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, SEL_W, 64'h0}},
		'{32'h0000_0000, 32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, SEL_X, 64'h1}},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hC000_0000, 1'b1,
			'{1'b0, SEL_Z, 64'h3}},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1,
			'{1'b0, SEL_Y, 64'h2}},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
			'{1'b1, SEL_W, 64'h7FDF_F7FC}},
		'{32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 1'b1,
			'{1'b1, SEL_W, 64'h7FDF_F7FC}},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1,
			'{1'b1, SEL_W, 64'h7FDF_F7FC}},
		'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b1, SEL_X, 64'h805}},
		'{32'h4000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{1'b0, SEL_W, 64'h0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, SEL_W, 64'h0}},
		'{32'h2000_0000, 32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 1'b0, '0},
		'{32'h2000_0000, 32'hE000_0000, 32'h2000_0000, 32'hE000_0000, 1'b0, '0},
		'{32'hC000_0000, 32'h1000_0000, 32'hF000_0000, 32'h0000_0000, 1'b0, '0},
		'{32'h4000_0000, 32'h2D41_3CCD, 32'hD2BE_C333, 32'h2D41_3CCC, 1'b0, '0},
		'{32'h1555_5555, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h2AAA_AAAA, 1'b0, '0},
		'{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002, 32'h0010_0000, 1'b0, '0},
		'{32'h0000_0000, 32'h0000_0000, 32'h3000_0000, 32'hD000_0000, 1'b0, '0},
		'{32'h3FFF_FFFF, 32'h0000_0400, 32'hFFFF_FC00, 32'h0000_0201, 1'b0, '0},
		'{32'h8000_0001, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0, '0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata   = '0;   // comp_w, comp_x, comp_y, comp_z
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;          // packed_word, largest_index, clipped
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data  = 1'b0; // format_select

	pack_result_t pending_packs [$];
	logic         fmt_now        = FMT_SHORT;
	int           send_gap_pct   = 0;
	int           recv_stall_pct = 0;
	int           hold_left      = 0;
	int           quiet_cycles   = 0;
	int           fail_count     = 0;

	quaternion_smallest_three_pack_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic pack_result_t pack_smallest_three(input logic [IN_W-1:0] quat,
			input logic fmt);
		logic [CW-1:0]   comp;
		logic [CW-1:0]   mag [NUM_COMP];
		logic            neg [NUM_COMP];
		logic [127:0]    prod;
		logic [63:0]     lim;
		logic [63:0]     r;
		logic [63:0]     fld;
		int              bits;
		int              k;
		int              big;
		pack_result_t    res;
		bits = (fmt == FMT_LONG) ? LONG_B : SHORT_B;
		lim  = (64'd1 << (bits - 1)) - 64'd1;
		for (int i = 0; i < NUM_COMP; i++) begin
			comp   = quat[i*CW +: CW];
			neg[i] = comp[CW-1];
			mag[i] = neg[i] ? -comp : comp;
		end
		big = 0;
		for (int i = 1; i < NUM_COMP; i++) begin
			if (mag[i] > mag[big]) begin
				big = i;
			end
		end
		res.word    = 64'(big);
		res.sel     = idx_t'(big);
		res.clipped = 1'b0;
		k = 0;
		for (int i = 0; i < NUM_COMP; i++) begin
			if (i != big) begin
				prod = (128'(mag[i]) > (128'd1 << FRAC)) ? (128'd1 << FRAC) : 128'(mag[i]);
				prod = prod * 128'(lim) * 128'(SQRT2_Q32) + (128'd1 << (FRAC + 31));
				r    = 64'(prod >> (FRAC + 32));
				if (r > lim) begin
					r           = lim;
					res.clipped = 1'b1;
				end
				fld = (neg[i] != neg[big]) ? -r : r;
				fld &= (64'd1 << bits) - 64'd1;
				res.word |= fld << (2 + k * bits);
				k++;
			end
		end
		return res;
	endfunction

	function automatic logic [IN_W-1:0] random_quat();
		logic [CW-1:0] c [NUM_COMP];
		logic [CW-1:0] mag;
		int            kind;
		int            big;
		int            dst;
		kind = $urandom_range(0, 9);
		big  = $urandom_range(0, NUM_COMP - 1);
		for (int i = 0; i < NUM_COMP; i++) begin
			if (kind <= 1) begin
				c[i] = $urandom;
			end else if (kind <= 7) begin
				if (i == big)
					mag = $urandom_range(NEAR_CLIP + 1, 32'h4000_0000);
				else if ($urandom_range(0, 7) == 0)
					mag = $urandom_range(NEAR_CLIP - 2000, NEAR_CLIP);
				else
					mag = $urandom_range(0, NEAR_CLIP);
				c[i] = $urandom_range(0, 1) ? -mag : mag;
			end else if (kind == 8) begin
				mag  = $urandom >> $urandom_range(8, CW - 1);
				c[i] = $urandom_range(0, 1) ? -mag : mag;
			end else begin
				case ($urandom_range(0, 7))
					0: c[i] = 32'h0000_0000;
					1: c[i] = 32'h0000_0001;
					2: c[i] = 32'hFFFF_FFFF;
					3: c[i] = 32'h7FFF_FFFF;
					4: c[i] = 32'h8000_0000;
					5: c[i] = 32'h8000_0001;
					6: c[i] = 32'h4000_0000;
					default: c[i] = 32'hC000_0000;
				endcase
			end
		end
		// tie with the largest component, same or opposite sign
		if (kind == 7) begin
			dst    = $urandom_range(0, NUM_COMP - 1);
			c[dst] = $urandom_range(0, 1) ? -c[big] : c[big];
		end
		return {c[3], c[2], c[1], c[0]};
	endfunction

	task automatic send_quat(input logic [IN_W-1:0] quat, input pack_result_t want);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= quat;
		do @(posedge clk); while (!s_tready);
		pending_packs.push_back(want);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_packs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_format(input logic fmt);
		cfg_valid <= 1'b1;
		cfg_data  <= fmt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fmt_now = fmt;
	endtask

	task automatic walk_quat_rows(input logic use_typed);
		logic [IN_W-1:0] quat;
		for (int n = 0; n < NUM_ROWS; n++) begin
			quat = {QUAT_ROWS[n].z, QUAT_ROWS[n].y, QUAT_ROWS[n].x, QUAT_ROWS[n].w};
			if (use_typed && QUAT_ROWS[n].typed)
				send_quat(quat, QUAT_ROWS[n].want);
			else
				send_quat(quat, pack_smallest_three(quat, fmt_now));
		end
		drain_results();
	endtask

	task automatic run_random_phase(input logic fmt, input int gap_pct, input int stall_pct,
			input int count, input int hold_at, input int pause_at);
		logic [IN_W-1:0] quat;
		write_format(fmt);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_left = HOLD_CYCLES;
			if (n == pause_at)
				drain_results();
			quat = random_quat();
			send_quat(quat, pack_smallest_three(quat, fmt_now));
		end
		drain_results();
	endtask

	always @(posedge clk) begin : check_words
		pack_result_t got;
		pack_result_t want;
		got = pack_result_t'(m_tdata[$bits(pack_result_t)-1:0]);
		if (m_tvalid && m_tready) begin
			if (pending_packs.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_tdata);
				fail_count++;
			end else begin
				want = pending_packs.pop_front();
				if (got.word !== want.word) begin
					$display("%0t: packed_word expected %h actual %h", $time, want.word, got.word);
					fail_count++;
				end
				if (got.sel !== want.sel) begin
					$display("%0t: largest_index expected %0d actual %0d", $time, want.sel,
						got.sel);
					fail_count++;
				end
				if (got.clipped !== want.clipped) begin
					$display("%0t: clipped expected %b actual %b", $time, want.clipped,
						got.clipped);
					fail_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		walk_quat_rows(1'b1);
		write_format(FMT_LONG);
		walk_quat_rows(1'b0);
		run_random_phase(FMT_LONG,   0,  0, 150, 50,      NO_MARK);
		run_random_phase(FMT_SHORT, 79,  0, 150, NO_MARK, NO_MARK);
		run_random_phase(FMT_SHORT,  0, 79, 150, NO_MARK, NO_MARK);
		run_random_phase(FMT_LONG,  14, 14, 150, NO_MARK, 75);
		run_random_phase(FMT_LONG,   0, 79, 150, NO_MARK, NO_MARK);
		run_random_phase(FMT_SHORT, 14, 14, 150, 40,      NO_MARK);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
